/* design/seek_arrive_steering_macros.svh */
// ----------------------------------------------------------------------------
// seek_arrive_steering_macros.svh
// Assertion macros shared by the steering block.
// ----------------------------------------------------------------------------
`ifndef SEEK_ARRIVE_STEERING_MACROS_SVH
`define SEEK_ARRIVE_STEERING_MACROS_SVH

// Same-cycle implication
`define SAS_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication
`define SAS_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

/* design/sas_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_pkg
// Shared types for the steering block and its arithmetic unit.
// ----------------------------------------------------------------------------
package sas_pkg;

    // Operations of the shared arithmetic unit
    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } op_t;

    // Command from the sequencer
    typedef struct packed {
        logic start;
        op_t  op;
    } alu_req_t;

    // Unit status
    typedef struct packed {
        logic busy;
        logic done;
    } alu_stat_t;

    localparam int unsigned MUL_STEPS  = 64;
    localparam int unsigned DIV_STEPS  = 128;
    localparam int unsigned SQRT_STEPS = 64;

endpackage

/* design/sas_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_alu
// Bit-serial shared unit: 64x64 multiply, 128/64 divide, 128-bit square root.
// ----------------------------------------------------------------------------
module sas_alu (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sas_pkg::alu_req_t    req,
    input  logic [63:0]          a,      // multiplicand / divisor
    input  logic [63:0]          b,      // multiplier
    input  logic [127:0]         n,      // dividend / radicand
    output sas_pkg::alu_stat_t   stat,
    output logic [63:0]          q,      // quotient / root
    output logic [127:0]         p       // product
);

    sas_pkg::op_t  op_reg;
    logic [63:0]   a_reg, b_reg, q_reg;
    logic [127:0]  work_reg;
    logic [65:0]   rem_reg;
    logic [6:0]    cnt_reg;
    logic          busy_reg, done_reg;

    logic [63:0]   b_next, q_next;
    logic [127:0]  work_next;
    logic [65:0]   rem_next;
    logic [64:0]   dr;
    logic          dge;
    logic [67:0]   sr, strial;
    logic          sge;

    // One iteration of the selected operation
    always_comb
    begin
        dr        = {rem_reg[63:0], work_reg[127]};
        dge       = (dr >= {1'b0, a_reg});
        sr        = {rem_reg, work_reg[127:126]};
        strial    = {2'b00, q_reg, 2'b01};
        sge       = (sr >= strial);
        b_next    = b_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        work_next = work_reg;
        case (op_reg)
            sas_pkg::OP_MUL:
            begin
                work_next = {work_reg[126:0], 1'b0}
                          + (b_reg[63] ? {64'd0, a_reg} : 128'd0);
                b_next    = {b_reg[62:0], 1'b0};
            end
            sas_pkg::OP_DIV:
            begin
                rem_next  = dge ? {1'b0, dr - {1'b0, a_reg}} : {1'b0, dr};
                q_next    = {q_reg[62:0], dge};
                work_next = {work_reg[126:0], 1'b0};
            end
            sas_pkg::OP_SQRT:
            begin
                rem_next  = sge ? 66'(sr - strial) : sr[65:0];
                q_next    = {q_reg[62:0], sge};
                work_next = {work_reg[125:0], 2'b00};
            end
            default:
            begin
                work_next = work_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= sas_pkg::OP_MUL;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            op_reg   <= req.op;
            case (req.op)
                sas_pkg::OP_DIV:  cnt_reg <= 7'(sas_pkg::DIV_STEPS - 1);
                sas_pkg::OP_SQRT: cnt_reg <= 7'(sas_pkg::SQRT_STEPS - 1);
                default:          cnt_reg <= 7'(sas_pkg::MUL_STEPS - 1);
            endcase
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 7'd1;
            if (cnt_reg == 7'd0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg    <= a;
            b_reg    <= b;
            q_reg    <= '0;
            rem_reg  <= '0;
            work_reg <= (req.op == sas_pkg::OP_MUL) ? 128'd0 : n;
        end
        else if (busy_reg)
        begin
            b_reg    <= b_next;
            q_reg    <= q_next;
            rem_reg  <= rem_next;
            work_reg <= work_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign q         = q_reg;
    assign p         = work_reg;

endmodule

/* design/seek_arrive_steering.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seek_arrive_steering
// Seek / arrive steering on Q16.16 vectors, sequenced over one shared unit.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  in      | in_valid/in_ready + 7 fields     | into block
//  out     | out_valid/out_ready + 3 fields   | out of block
//  cfg     | cfg_we, cfg_idx, cfg_data        | into block, write only
//
//  Every step runs on one bit-serial unit: multiply, divide or square root.
//  Seek takes 7 ops, arrive up to 19 ops. One item at a time; in_ready is
//  low until the result transfer completes. Reset clears control and the
//  latch and loads the configuration defaults; datapath registers are not
//  reset. A stalled output holds; no new input is taken meanwhile.
// ----------------------------------------------------------------------------
`include "seek_arrive_steering_macros.svh"

module seek_arrive_steering (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [31:0] target_x,
    input  logic [31:0] target_y,
    input  logic [31:0] char_x,
    input  logic [31:0] char_y,
    input  logic [31:0] vel_x,
    input  logic [31:0] vel_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] lin_x,
    output logic [31:0] lin_y,
    output logic        arrived,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [31:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_WAIT  = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    typedef enum logic [4:0] {
        P_SQX, P_SQY, P_DIST, P_TSM, P_TSD, P_NUMX, P_DIVX, P_NUMY, P_DIVY,
        P_EX, P_EY, P_AX, P_AY, P_MA, P_LEN, P_CXM, P_CXD, P_CYM, P_CYD
    } step_t;

    typedef enum logic [2:0] {
        R_MAX_SPEED = 3'd0,
        R_TGT_RAD   = 3'd1,
        R_SLOW_RAD  = 3'd2,
        R_TTT       = 3'd3,
        R_MAX_ACC   = 3'd4
    } reg_idx_t;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;

    // Configuration
    logic [31:0] ms_reg, tr_reg, sr_reg, ttt_reg, ma_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg  <= 32'd65536;
            tr_reg  <= 32'd65536;
            sr_reg  <= 32'd327680;
            ttt_reg <= 32'd6554;
            ma_reg  <= 32'd655360;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_idx))
                R_MAX_SPEED: ms_reg  <= cfg_data;
                R_TGT_RAD:   tr_reg  <= cfg_data;
                R_SLOW_RAD:  sr_reg  <= cfg_data;
                R_TTT:       ttt_reg <= cfg_data;
                R_MAX_ACC:   ma_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Item working registers
    logic          mode_reg, sgx_reg, sgy_reg, oxs_reg, oys_reg, latch_reg;
    logic [32:0]   mx_reg, my_reg;
    logic [31:0]   vx_reg, vy_reg, ts_reg;
    logic [63:0]   den_reg, qx_reg, ox_reg, oy_reg;
    logic [127:0]  t_reg, acc_reg, num_reg;

    // Unit hookup
    sas_pkg::alu_req_t  req;
    sas_pkg::alu_stat_t stat;
    logic [63:0]        ua, ub, uq;
    logic [127:0]       un, up;

    sas_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .a     (ua),
        .b     (ub),
        .n     (un),
        .stat  (stat),
        .q     (uq),
        .p     (up)
    );

    // Velocity error from desired velocity (qx/oy hold its magnitudes)
    logic signed [34:0] desx, desy, ex, ey;
    logic [34:0]        exm, eym;
    logic [63:0]        kval, ttt_eff;
    always_comb
    begin
        desx    = sgx_reg ? -$signed({2'b00, qx_reg[32:0]}) : $signed({2'b00, qx_reg[32:0]});
        desy    = sgy_reg ? -$signed({2'b00, oy_reg[32:0]}) : $signed({2'b00, oy_reg[32:0]});
        ex      = desx - 35'(signed'(vx_reg));
        ey      = desy - 35'(signed'(vy_reg));
        exm     = ex[34] ? 35'(-ex) : 35'(ex);
        eym     = ey[34] ? 35'(-ey) : 35'(ey);
        kval    = mode_reg ? {32'd0, ts_reg} : {32'd0, ms_reg};
        ttt_eff = (ttt_reg == 32'd0) ? 64'd1 : {32'd0, ttt_reg};
    end

    // Operand selection per step
    always_comb
    begin
        req.start = (state_reg == S_ISSUE);
        req.op    = sas_pkg::OP_MUL;
        ua        = '0;
        ub        = '0;
        un        = '0;
        case (step_reg)
            P_SQX:  begin ua = {31'd0, mx_reg}; ub = {31'd0, mx_reg}; end
            P_SQY:  begin ua = {31'd0, my_reg}; ub = {31'd0, my_reg}; end
            P_DIST: begin req.op = sas_pkg::OP_SQRT; un = acc_reg; end
            P_TSM:  begin ua = {32'd0, ms_reg}; ub = den_reg; end
            P_TSD:  begin req.op = sas_pkg::OP_DIV; un = num_reg; ua = {32'd0, sr_reg}; end
            P_NUMX: begin ua = {31'd0, mx_reg}; ub = kval; end
            P_NUMY: begin ua = {31'd0, my_reg}; ub = kval; end
            P_DIVX, P_DIVY, P_CXD, P_CYD:
            begin
                req.op = sas_pkg::OP_DIV; un = num_reg; ua = den_reg;
            end
            P_EX:   begin req.op = sas_pkg::OP_DIV; un = {77'd0, exm, 16'd0}; ua = ttt_eff; end
            P_EY:   begin req.op = sas_pkg::OP_DIV; un = {77'd0, eym, 16'd0}; ua = ttt_eff; end
            P_AX:   begin ua = ox_reg; ub = ox_reg; end
            P_AY:   begin ua = oy_reg; ub = oy_reg; end
            P_MA:   begin ua = {32'd0, ma_reg}; ub = {32'd0, ma_reg}; end
            P_LEN:  begin req.op = sas_pkg::OP_SQRT; un = acc_reg; end
            P_CXM:  begin ua = ox_reg; ub = {32'd0, ma_reg}; end
            P_CYM:  begin ua = oy_reg; ub = {32'd0, ma_reg}; end
            default: ;
        endcase
    end

    // Offsets at acceptance
    logic signed [32:0] dx, dy;
    assign dx = 33'(signed'(target_x)) - 33'(signed'(char_x));
    assign dy = 33'(signed'(target_y)) - 33'(signed'(char_y));

    // Sequencer
    logic in_xfer;
    assign in_xfer = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:  if (in_xfer) begin state_next = S_ISSUE; step_next = P_SQX; end
            S_ISSUE: state_next = S_WAIT;
            S_WAIT:
            begin
                if (stat.done)
                begin
                    state_next = S_ISSUE;
                    case (step_reg)
                        P_SQX:  step_next = P_SQY;
                        P_SQY:  step_next = P_DIST;
                        P_DIST:
                        begin
                            if (!mode_reg)
                            begin
                                if (uq == 64'd0) state_next = S_OUT;
                                else             step_next  = P_NUMX;
                            end
                            else if (uq < {32'd0, tr_reg}) state_next = S_OUT;
                            else if (uq == 64'd0)           step_next  = P_EX;
                            else if (uq > {32'd0, sr_reg})  step_next  = P_NUMX;
                            else                            step_next  = P_TSM;
                        end
                        P_TSM:  step_next = P_TSD;
                        P_TSD:  step_next = P_NUMX;
                        P_NUMX: step_next = P_DIVX;
                        P_DIVX: step_next = P_NUMY;
                        P_NUMY: step_next = P_DIVY;
                        P_DIVY:
                        begin
                            if (mode_reg) step_next  = P_EX;
                            else          state_next = S_OUT;
                        end
                        P_EX:   step_next = P_EY;
                        P_EY:   step_next = P_AX;
                        P_AX:   step_next = P_AY;
                        P_AY:   step_next = P_MA;
                        P_MA:
                        begin
                            if (acc_reg > up) step_next  = P_LEN;
                            else              state_next = S_OUT;
                        end
                        P_LEN:  step_next = P_CXM;
                        P_CXM:  step_next = P_CXD;
                        P_CXD:  step_next = P_CYM;
                        P_CYM:  step_next = P_CYD;
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= P_SQX;
            latch_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (state_reg == S_WAIT && stat.done && step_reg == P_DIST && mode_reg
                && uq < {32'd0, tr_reg})
            begin
                latch_reg <= 1'b1;
            end
        end
    end

    // Datapath captures
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg <= req_type;
            sgx_reg  <= dx[32];
            sgy_reg  <= dy[32];
            mx_reg   <= dx[32] ? 33'(-dx) : 33'(dx);
            my_reg   <= dy[32] ? 33'(-dy) : 33'(dy);
            vx_reg   <= vel_x;
            vy_reg   <= vel_y;
        end
        else if (state_reg == S_WAIT && stat.done)
        begin
            case (step_reg)
                P_SQX:  t_reg <= up;
                P_SQY:  acc_reg <= t_reg + up;
                P_DIST:
                begin
                    den_reg <= uq;
                    ts_reg  <= ms_reg;
                    qx_reg  <= '0;
                    ox_reg  <= '0;
                    oy_reg  <= '0;
                    oxs_reg <= 1'b0;
                    oys_reg <= 1'b0;
                end
                P_TSM, P_NUMX, P_NUMY, P_CXM, P_CYM: num_reg <= up;
                P_TSD:  ts_reg <= uq[31:0];
                P_DIVX: qx_reg <= uq;
                P_DIVY:
                begin
                    oy_reg  <= uq;
                    ox_reg  <= qx_reg;
                    oxs_reg <= sgx_reg;
                    oys_reg <= sgy_reg;
                end
                P_EX:   begin ox_reg <= uq; oxs_reg <= ex[34]; end
                P_EY:   begin oy_reg <= uq; oys_reg <= ey[34]; end
                P_AX:   t_reg <= up;
                P_AY:   acc_reg <= t_reg + up;
                P_LEN:  den_reg <= uq;
                P_CXD:  ox_reg <= uq;
                P_CYD:  oy_reg <= uq;
                default: ;
            endcase
        end
    end

    // Saturate sign/magnitude into signed 32 bits
    function automatic logic [31:0] sat32(input logic s, input logic [63:0] m);
        logic [31:0] r;
        if (s && m != 64'd0)
        begin
            if (m >= 64'h8000_0000) r = 32'h8000_0000;
            else                    r = 32'(-m[31:0]);
        end
        else if (m > 64'h7FFF_FFFF) r = 32'h7FFF_FFFF;
        else                        r = m[31:0];
        return r;
    endfunction

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign lin_x     = sat32(oxs_reg, ox_reg);
    assign lin_y     = sat32(oys_reg, oy_reg);
    assign arrived   = latch_reg;

    `SAS_ASSERT_IMP(a_ready_valid_excl, 1'b1, !(in_ready && out_valid), "ready and valid together")
    `SAS_ASSERT_NXT(a_accept_issue, in_valid && in_ready, state_reg == S_ISSUE, "no issue after accept")
    `SAS_ASSERT_NXT(a_latch_sticky, arrived, arrived, "arrived latch dropped")
    `SAS_ASSERT_IMP(a_busy_wait, stat.busy, state_reg == S_WAIT, "unit busy outside wait")

endmodule

/* verif/seek_arrive_steering_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seek_arrive_steering_tb
// Self-checking bench for the seek / arrive steering block. A directed table
// covers the field extremes and the corner cases: zero offset, the arrival
// radius, a zero slow radius, a zero correction time and a zero acceleration
// clamp. Random phases follow, each with its own register setting and one of
// four idle and stall patterns. Every result is checked against a bit-exact
// fixed-point predictor, or against the given result for a typed row.
// ----------------------------------------------------------------------------
module seek_arrive_steering_tb;

    // Register indexes
    localparam logic [2:0] REG_MAX_SPEED  = 3'd0;
    localparam logic [2:0] REG_TGT_RADIUS = 3'd1;
    localparam logic [2:0] REG_SLOW_RAD   = 3'd2;
    localparam logic [2:0] REG_TTT        = 3'd3;
    localparam logic [2:0] REG_MAX_ACCEL  = 3'd4;
    localparam int unsigned NUM_REGS      = 5;

    // Request modes
    localparam bit REQ_SEEK   = 1'b0;
    localparam bit REQ_ARRIVE = 1'b1;

    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned RAND_ITEMS  = 1280;
    localparam int unsigned NUM_PHASES  = 8;

    typedef struct {
        logic [31:0] lx;
        logic [31:0] ly;
        logic        arr;
    } steer_res_t;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [31:0] data;
        bit          req;
        logic [31:0] tx, ty, cx, cy, vx, vy;
        bit          typed;
        steer_res_t  res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        req_type;
    logic [31:0] target_x, target_y, char_x, char_y, vel_x, vel_y;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] lin_x, lin_y;
    logic        arrived;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;

    // Predictor state
    logic [31:0] shadow_reg [NUM_REGS];
    bit          shadow_latch;

    steer_res_t  steer_expected [$];
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    stim_row_t   dir_tab [$];

    seek_arrive_steering dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .target_x  (target_x),
        .target_y  (target_y),
        .char_x    (char_x),
        .char_y    (char_y),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .lin_x     (lin_x),
        .lin_y     (lin_y),
        .arrived   (arrived),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Fixed-point helpers
    // ------------------------------------------------------------------
    function automatic logic [127:0] wide_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] r;
        r = {64'd0, a} * {64'd0, b};
        return r;
    endfunction

    function automatic logic [63:0] abs_val(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (wide_mul(c, c) <= v) r = c;
        end
        return r;
    endfunction

    // sign(s) * |s| * m / d, truncated
    function automatic longint ratio_scale(input longint s, input logic [63:0] m,
                                           input logic [63:0] d);
        logic [127:0] q;
        q = wide_mul(abs_val(s), m) / {64'd0, d};
        return (s < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic logic [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    // ------------------------------------------------------------------
    // Steering predictor; updates the arrival latch copy
    // ------------------------------------------------------------------
    function automatic steer_res_t steer_predict(input bit req,
            input logic [31:0] tx, ty, cx, cy, vx, vy);
        longint       dx, dy, ox, oy, desx, desy, ex, ey;
        logic [63:0]  dist_val, ts, ttt, len;
        logic [127:0] a2;
        steer_res_t   r;
        dx = longint'($signed(tx)) - longint'($signed(cx));
        dy = longint'($signed(ty)) - longint'($signed(cy));
        dist_val = floor_sqrt(wide_mul(abs_val(dx), abs_val(dx))
                              + wide_mul(abs_val(dy), abs_val(dy)));
        ox = 0;
        oy = 0;
        if (req == REQ_SEEK) begin
            if (dist_val != 0) begin
                ox = ratio_scale(dx, {32'd0, shadow_reg[REG_MAX_SPEED]}, dist_val);
                oy = ratio_scale(dy, {32'd0, shadow_reg[REG_MAX_SPEED]}, dist_val);
            end
        end else if (dist_val < {32'd0, shadow_reg[REG_TGT_RADIUS]}) begin
            shadow_latch = 1'b1;
        end else begin
            if (dist_val > {32'd0, shadow_reg[REG_SLOW_RAD]})
                ts = {32'd0, shadow_reg[REG_MAX_SPEED]};
            else if (shadow_reg[REG_SLOW_RAD] == 0)
                ts = '0;
            else
                ts = 64'(wide_mul({32'd0, shadow_reg[REG_MAX_SPEED]}, dist_val)
                         / {96'd0, shadow_reg[REG_SLOW_RAD]});
            desx = 0;
            desy = 0;
            if (dist_val != 0) begin
                desx = ratio_scale(dx, ts, dist_val);
                desy = ratio_scale(dy, ts, dist_val);
            end
            ex = desx - longint'($signed(vx));
            ey = desy - longint'($signed(vy));
            ttt = (shadow_reg[REG_TTT] != 0) ? {32'd0, shadow_reg[REG_TTT]} : 64'd1;
            ox = ratio_scale(ex, 64'd65536, ttt);
            oy = ratio_scale(ey, 64'd65536, ttt);
            a2 = wide_mul(abs_val(ox), abs_val(ox)) + wide_mul(abs_val(oy), abs_val(oy));
            // Clamp the length to max_accel
            if (a2 > wide_mul({32'd0, shadow_reg[REG_MAX_ACCEL]},
                              {32'd0, shadow_reg[REG_MAX_ACCEL]})) begin
                len = floor_sqrt(a2);
                ox = ratio_scale(ox, {32'd0, shadow_reg[REG_MAX_ACCEL]}, len);
                oy = ratio_scale(oy, {32'd0, shadow_reg[REG_MAX_ACCEL]}, len);
            end
        end
        r.lx  = clip32(ox);
        r.ly  = clip32(oy);
        r.arr = shadow_latch;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus tasks (called at the falling edge)
    // ------------------------------------------------------------------
    task automatic send_item(input bit req, input logic [31:0] tx, ty, cx, cy, vx, vy,
                             input bit typed, input steer_res_t typed_res);
        steer_res_t p;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
        end
        req_type <= req;
        target_x <= tx;
        target_y <= ty;
        char_x   <= cx;
        char_y   <= cy;
        vel_x    <= vx;
        vel_y    <= vy;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        p = steer_predict(req, tx, ty, cx, cy, vx, vy);
        steer_expected.push_back(typed ? typed_res : p);
        @(negedge clk);
    endtask

    // Hold the sender until every result is back and the block is quiet
    task automatic drain();
        in_valid <= 1'b0;
        while (steer_expected.size() != 0 || out_valid) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we   <= 1'b0;
        shadow_reg[idx] = data;
        @(negedge clk);
    endtask

    function automatic stim_row_t item_row(input bit req,
            input logic [31:0] tx, ty, cx, cy, vx, vy);
        stim_row_t r;
        r = '{default: '0};
        r.req = req;
        r.tx = tx; r.ty = ty; r.cx = cx; r.cy = cy; r.vx = vx; r.vy = vy;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input bit req,
            input logic [31:0] tx, ty, cx, cy, vx, vy,
            input logic [31:0] lx, ly, input logic arr);
        stim_row_t r;
        r = item_row(req, tx, ty, cx, cy, vx, vy);
        r.typed = 1'b1;
        r.res = '{lx, ly, arr};
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [2:0] idx, input logic [31:0] data);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic logic [31:0] rand_reg_val();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hffffffff;
            2:       return $urandom;
            default: return $urandom_range(1, 16) * $urandom_range(256, 65536);
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            default: return 32'($signed($urandom_range(0, 40 * 65536)) - 20 * 65536);
        endcase
    endfunction

    function automatic logic [31:0] near_offset();
        case ($urandom_range(0, 2))
            0:       return 32'($signed($urandom_range(0, 1024)) - 512);
            default: return 32'($signed($urandom_range(0, 12 * 65536)) - 6 * 65536);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver backpressure
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        steer_res_t e;
        if (rst_n && out_valid && out_ready) begin
            if (steer_expected.size() == 0) begin
                $error("unexpected result transfer lin_x %h lin_y %h", lin_x, lin_y);
                mismatches++;
            end else begin
                e = steer_expected.pop_front();
                if (lin_x !== e.lx) begin
                    $error("lin_x expected %h actual %h", e.lx, lin_x);
                    mismatches++;
                end
                if (lin_y !== e.ly) begin
                    $error("lin_y expected %h actual %h", e.ly, lin_y);
                    mismatches++;
                end
                if (arrived !== e.arr) begin
                    $error("arrived expected %b actual %b", e.arr, arrived);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer at all
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [31:0] cx, cy;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        req_type  = 1'b0;
        target_x  = '0;
        target_y  = '0;
        char_x    = '0;
        char_y    = '0;
        vel_x     = '0;
        vel_y     = '0;
        cfg_we    = 1'b0;
        cfg_idx   = '0;
        cfg_data  = '0;
        shadow_reg[REG_MAX_SPEED]  = 32'd65536;
        shadow_reg[REG_TGT_RADIUS] = 32'd65536;
        shadow_reg[REG_SLOW_RAD]   = 32'd327680;
        shadow_reg[REG_TTT]        = 32'd6554;
        shadow_reg[REG_MAX_ACCEL]  = 32'd655360;
        shadow_latch = 1'b0;

        // Directed table: reset values first
        dir_tab.push_back(typed_row(REQ_SEEK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(typed_row(REQ_SEEK, 32'd65536, 0, 0, 0, 0, 0, 32'd65536, 0, 0));
        dir_tab.push_back(typed_row(REQ_SEEK, 0, 32'hffff0000, 0, 0, 0, 0,
                                    0, 32'hffff0000, 0));
        dir_tab.push_back(item_row(REQ_SEEK, 32'h7fffffff, 32'h7fffffff,
                                   32'h80000000, 32'h80000000, 0, 0));
        dir_tab.push_back(item_row(REQ_SEEK, 32'h80000000, 32'h7fffffff,
                                   32'h7fffffff, 32'h80000000, 32'hffffffff, 32'hffffffff));
        dir_tab.push_back(item_row(REQ_ARRIVE, 32'h7fffffff, 0, 32'h80000000, 0,
                                   32'h7fffffff, 32'h7fffffff));
        dir_tab.push_back(item_row(REQ_ARRIVE, 0, 32'h80000000, 0, 32'h7fffffff,
                                   32'h80000000, 32'h80000000));
        dir_tab.push_back(item_row(REQ_ARRIVE, 32'd196608, 32'd65536, 0, 0, 0, 0));
        dir_tab.push_back(item_row(REQ_ARRIVE, 32'd65536, 0, 0, 0, 32'd1000, 0));
        dir_tab.push_back(typed_row(REQ_ARRIVE, 32'd1234, 32'd5678, 32'd1234, 32'd5678,
                                    32'd99, 32'd99, 0, 0, 1));
        dir_tab.push_back(item_row(REQ_SEEK, 32'd300000, 32'd7, 0, 0, 0, 0));
        // Top speed and acceleration
        dir_tab.push_back(cfg_row(REG_MAX_SPEED, 32'hffffffff));
        dir_tab.push_back(cfg_row(REG_MAX_ACCEL, 32'hffffffff));
        dir_tab.push_back(cfg_row(REG_TTT, 32'hffffffff));
        dir_tab.push_back(item_row(REQ_SEEK, 32'h40000000, 32'h12345678, 0, 0, 0, 0));
        dir_tab.push_back(item_row(REQ_ARRIVE, 32'h7fffffff, 32'h7fffffff,
                                   32'h80000000, 32'h80000000, 32'h80000000, 0));
        // Zero radii, zero correction time, zero clamp
        dir_tab.push_back(cfg_row(REG_TGT_RADIUS, 32'd0));
        dir_tab.push_back(cfg_row(REG_SLOW_RAD, 32'd0));
        dir_tab.push_back(cfg_row(REG_TTT, 32'd0));
        dir_tab.push_back(cfg_row(REG_MAX_ACCEL, 32'd0));
        dir_tab.push_back(typed_row(REQ_ARRIVE, 32'd5, 32'd5, 32'd5, 32'd5, 0, 0, 0, 0, 1));
        dir_tab.push_back(item_row(REQ_ARRIVE, 32'd5, 32'd5, 32'd5, 32'd5,
                                   32'd3, 32'hfffffffd));
        dir_tab.push_back(cfg_row(REG_MAX_ACCEL, 32'd655360));
        dir_tab.push_back(item_row(REQ_ARRIVE, 32'd5, 32'd5, 32'd5, 32'd5,
                                   32'h00010000, 32'hffff0000));
        dir_tab.push_back(item_row(REQ_ARRIVE, 32'd70000, 0, 0, 0, 32'd1, 32'd2));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed table
        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg) begin
                drain();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end else begin
                send_item(dir_tab[i].req, dir_tab[i].tx, dir_tab[i].ty, dir_tab[i].cx,
                          dir_tab[i].cy, dir_tab[i].vx, dir_tab[i].vy,
                          dir_tab[i].typed, dir_tab[i].res);
            end
        end

        // Random phases: new setting, then a burst under one idle pattern
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            for (int r = 0; r < NUM_REGS; r++) write_reg(3'(r), rand_reg_val());
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            for (int n = 0; n < RAND_ITEMS / NUM_PHASES; n++) begin
                cx = rand_coord();
                cy = rand_coord();
                if ($urandom_range(0, 2) == 0)
                    send_item(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), cx, cy,
                              $urandom, $urandom, 1'b0, '{0, 0, 0});
                else
                    send_item(1'($urandom_range(0, 1)), cx + near_offset(),
                              cy + near_offset(), cx, cy, rand_coord(), rand_coord(),
                              1'b0, '{0, 0, 0});
            end
        end

        in_valid <= 1'b0;
        while (steer_expected.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/sas_pkg.sv
design/sas_alu.sv
design/seek_arrive_steering.sv
verif/seek_arrive_steering_tb.sv
